// ===== rtl/core/rgbc_pkg.sv =====
// shared types, constants and helpers for the rgba 3x3 convolution unit
package rgbc_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int SumW      = 30;
  localparam int QuoW      = 30;
  localparam int DivW      = 16;

  localparam logic [2:0] CfgKTop = 3'd0;
  localparam logic [2:0] CfgKMid = 3'd1;
  localparam logic [2:0] CfgKBot = 3'd2;
  localparam logic [2:0] CfgDiv  = 3'd3;
  localparam logic [2:0] CfgWid  = 3'd4;
  localparam logic [2:0] CfgHgt  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_WAIT
  } ctl_state_t;

  // one output job: position, window row and column selection and flags
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            top_dup;
    logic            left_dup;
    logic [1:0]      rc;
    logic [1:0]      cc;
    logic            run_last;
    logic            frame_last;
  } job_t;

  // control from sequencer to lanes
  typedef struct packed {
    logic start;
    job_t job;
  } lane_ctl_t;

  // lane status back to sequencer
  typedef struct packed {
    logic done;
  } lane_sts_t;

  function automatic logic signed [15:0] coef(input logic [47:0] row, input int k);
    coef = row[16*k +: 16];
  endfunction

endpackage

// ===== rtl/core/rgbc_ram.sv =====
// generic single port ram with registered read
module rgbc_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // read before write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/rgbc_lane.sv =====
// one color channel: 3x3 multiply-accumulate, serial divide, saturation
module rgbc_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [8:0][7:0]        win,
  input  logic                   top_dup,
  input  logic                   left_dup,
  input  logic [1:0]             rc,
  input  logic [1:0]             cc,
  input  logic [2:0][47:0]       krows,
  input  logic [rgbc_pkg::DivW-1:0] dvs,
  output logic                   done,
  output logic [7:0]             result
);
  import rgbc_pkg::*;

  logic                  mac_on;
  logic signed [SumW-1:0] acc;
  logic [1:0]            ra;
  logic [1:0]            cb;
  logic [1:0]            wr;
  logic [1:0]            wc;
  logic [3:0]            widx;
  logic signed [24:0]    prod;
  logic                  div_on;
  logic [5:0]            dcnt;
  logic                  neg;
  logic [QuoW-1:0]       num;
  logic [QuoW-1:0]       quo;
  logic [DivW:0]         rem;
  logic [DivW:0]         rem_sh;
  logic [DivW-1:0]       dv;

  // window position for the current tap, with edge duplication
  always_comb begin
    case (ra)
      2'd0:    wr = top_dup ? rc : rc - 2'd1;
      2'd1:    wr = rc;
      default: wr = 2'd2;
    endcase
    case (cb)
      2'd0:    wc = left_dup ? cc : cc - 2'd1;
      2'd1:    wc = cc;
      default: wc = 2'd2;
    endcase
    widx = 4'(wr * 3 + wc);
    prod = $signed({1'b0, win[widx]}) * coef(krows[ra], int'(cb));
    rem_sh = {rem[DivW-1:0], num[QuoW-1]};
  end

  // nine mac steps then one restoring divide bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_on <= 1'b0;
      div_on <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mac_on <= 1'b1;
        ra     <= 2'd0;
        cb     <= 2'd0;
        acc    <= '0;
        dv     <= (dvs == '0) ? DivW'(1) : dvs;
      end else if (mac_on) begin
        acc <= acc + SumW'(prod);
        if (ra == 2'd2 && cb == 2'd2) begin
          mac_on <= 1'b0;
          div_on <= 1'b1;
          dcnt   <= '0;
          neg <= (acc + SumW'(prod)) < 0;
          num <= ((acc + SumW'(prod)) < 0) ? QuoW'(-(acc + SumW'(prod)))
                                            : QuoW'(acc + SumW'(prod));
          rem <= '0;
          quo <= '0;
        end else if (cb == 2'd2) begin
          cb <= 2'd0;
          ra <= ra + 2'd1;
        end else begin
          cb <= cb + 2'd1;
        end
      end else if (div_on) begin
        if (rem_sh >= {1'b0, dv}) begin
          rem <= rem_sh - {1'b0, dv};
          quo <= {quo[QuoW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[QuoW-2:0], 1'b0};
        end
        num  <= {num[QuoW-2:0], 1'b0};
        dcnt <= dcnt + 6'd1;
        if (dcnt == 6'(QuoW - 1)) begin
          div_on <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign result = neg ? 8'd0 : ((quo > QuoW'(255)) ? 8'd255 : quo[7:0]);
endmodule

// ===== rtl/core/rgbc_merge.sv =====
// merges lane results with job info into the output register
module rgbc_merge (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [3:0]             lane_done,
  input  logic [3:0][7:0]        lane_res,
  input  rgbc_pkg::job_t         job,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [3:0][7:0]        pix,
  output rgbc_pkg::job_t         job_out
);
  import rgbc_pkg::*;

  // output holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (&lane_done) begin
      out_valid <= 1'b1;
      pix       <= lane_res;
      job_out   <= job;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end
endmodule

// ===== rtl/core/rgba_convolution_3x3_unit.sv =====
// top level: line buffers, window, job sequencer, four channel lanes
// flow: an input transfer reads the line stores and shifts the window, then the
//   sequencer starts the lanes for each job it releases (mac, divide, merge)
// the input side is stalled until every job released by an input has finished
//   in the lanes; a new job starts only once the previous output is taken
// reset: sync active high clears counters, window, sequencer, config to identity kernel and 1024x1024 size
module rgba_convolution_3x3_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        run_last,
  output logic        frame_last
);
  import rgbc_pkg::*;

  logic [2:0][47:0] krows;
  logic [15:0]      dvs;
  logic [10:0]      fw;
  logic [10:0]      fh;
  logic [ColW-1:0]  wl;
  logic [RowW-1:0]  hl;
  logic [ColW-1:0]  in_col;
  logic [RowW-1:0]  in_row;
  logic [ColW-1:0]  c;
  logic [RowW-1:0]  r;
  logic             acc;
  logic [31:0]      px;
  logic [31:0]      up_q;
  logic [31:0]      lo_q;
  logic [31:0]      px_q;
  logic [ColW-1:0]  up_addr;
  logic [8:0][31:0] win;
  logic [ColW-1:0]  c_q;
  logic [RowW-1:0]  r_q;
  logic             lastc_q;
  logic             lastr_q;
  ctl_state_t       state;
  ctl_state_t       state_next;
  logic             shift_q;
  job_t [3:0]       jobs;
  logic [3:0]       jmask;
  logic [1:0]       jsel;
  logic [1:0]       jsel_next;
  lane_ctl_t        lctl;
  lane_sts_t        lsts;
  logic [3:0]       ldone;
  logic [3:0][7:0]  lres;
  logic [3:0][8:0][7:0] lwin;
  job_t             job_cur;
  job_t             job_out;
  job_t             job_hold;
  job_t             job_hold_q;
  logic [3:0][7:0]  opix;
  logic             pending;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      krows <= {48'd0, 48'h10000, 48'd0};
      dvs   <= 16'd1;
      fw    <= 11'd1024;
      fh    <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgKTop: krows[0] <= cfg_data;
        CfgKMid: krows[1] <= cfg_data;
        CfgKBot: krows[2] <= cfg_data;
        CfgDiv:  dvs <= cfg_data[15:0];
        CfgWid:  fw <= cfg_data[10:0];
        CfgHgt:  fh <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // clamped last positions and current position
  always_comb begin
    wl = (fw == 0) ? '0 : ((fw > 11'(MaxWidth)) ? ColW'(MaxWidth - 1) : ColW'(fw - 11'd1));
    hl = (fh == 0) ? '0 : ((fh > 11'(MaxHeight)) ? RowW'(MaxHeight - 1) : RowW'(fh - 11'd1));
    c  = (in_col > wl) ? wl : in_col;
    r  = (in_row > hl) ? hl : in_row;
    px = {in_alpha, in_blue, in_green, in_red};
  end

  assign in_stall = (state != ST_IDLE) || pending || shift_q;
  assign acc = in_valid && !in_stall;

  // upper store: read at the transfer, takes the old lower value in the next cycle
  assign up_addr = pending ? c_q : c;
  rgbc_ram #(.Width(32), .Depth(MaxWidth)) u_up (
    .clk(clk), .we(pending), .addr(up_addr), .wdata(lo_q), .rdata(up_q)
  );
  rgbc_ram #(.Width(32), .Depth(MaxWidth)) u_lo (
    .clk(clk), .we(acc), .addr(c), .wdata(px), .rdata(lo_q)
  );

  // input position counters and captured pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      pending <= 1'b0;
    end else begin
      pending <= acc;
      if (acc) begin
        px_q    <= px;
        c_q     <= c;
        r_q     <= r;
        lastc_q <= (c == wl);
        lastr_q <= (r == hl);
        if (c == wl) begin
          in_col <= '0;
          in_row <= (r == hl) ? '0 : r + RowW'(1);
        end else begin
          in_col <= c + ColW'(1);
          in_row <= r;
        end
      end
    end
  end

  // window shift once the line reads return
  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= '0;
      shift_q <= 1'b0;
    end else begin
      shift_q <= pending;
      if (pending) begin
        for (int k = 0; k < 3; k++) begin
          win[k*3]   <= win[k*3+1];
          win[k*3+1] <= win[k*3+2];
        end
        win[2] <= up_q;
        win[5] <= lo_q;
        win[8] <= px_q;
      end
    end
  end

  // jobs released by this input
  always_comb begin
    jobs  = '0;
    jmask = '0;
    jobs[0] = '{row: r_q - RowW'(1), col: c_q - ColW'(1), top_dup: (r_q == 1),
                left_dup: (c_q == 1), rc: 2'd1, cc: 2'd1, run_last: 1'b0,
                frame_last: 1'b0};
    jobs[1] = '{row: r_q - RowW'(1), col: c_q, top_dup: (r_q == 1),
                left_dup: (c_q == 0), rc: 2'd1, cc: 2'd2, run_last: 1'b0,
                frame_last: 1'b0};
    jobs[2] = '{row: r_q, col: c_q - ColW'(1), top_dup: (r_q == 0),
                left_dup: (c_q == 1), rc: 2'd2, cc: 2'd1, run_last: 1'b0,
                frame_last: 1'b0};
    jobs[3] = '{row: r_q, col: c_q, top_dup: (r_q == 0), left_dup: (c_q == 0),
                rc: 2'd2, cc: 2'd2, run_last: 1'b0, frame_last: 1'b1};
    jmask[0] = (r_q != 0) && (c_q != 0);
    jmask[1] = (r_q != 0) && lastc_q;
    jmask[2] = lastr_q && (c_q != 0);
    jmask[3] = lastr_q && lastc_q;
  end

  // job sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      jsel  <= '0;
    end else begin
      state <= state_next;
      jsel  <= jsel_next;
    end
  end

  always_comb begin
    logic more;
    state_next = state;
    jsel_next  = jsel;
    lctl       = '0;
    more       = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (k > int'(jsel) && jmask[k]) more = 1'b1;
    end
    job_cur = jobs[jsel];
    job_cur.run_last = !more;
    job_cur.frame_last = (jsel == 2'd3);
    lctl.job = job_cur;
    case (state)
      ST_IDLE: begin
        if (shift_q) begin
          if (jmask[0]) begin
            jsel_next = 2'd0; state_next = ST_EMIT;
          end else if (jmask[1]) begin
            jsel_next = 2'd1; state_next = ST_EMIT;
          end else if (jmask[2]) begin
            jsel_next = 2'd2; state_next = ST_EMIT;
          end else if (jmask[3]) begin
            jsel_next = 2'd3; state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid) begin
          lctl.start = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (lsts.done) begin
          state_next = ST_IDLE;
          for (int k = 3; k >= 0; k--) begin
            if (k > int'(jsel) && jmask[k]) begin
              jsel_next  = 2'(k);
              state_next = ST_EMIT;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // hold the active job for the merge stage
  always_ff @(posedge clk) begin
    if (lctl.start) job_hold <= lctl.job;
  end
  assign job_hold_q = lctl.start ? lctl.job : job_hold;

  assign lsts.done = &ldone;

  // four lanes, one per channel
  for (genvar g = 0; g < 4; g++) begin : g_lane
    for (genvar t = 0; t < 9; t++) begin : g_tap
      assign lwin[g][t] = win[t][8*g +: 8];
    end
    rgbc_lane u_lane (
      .clk(clk), .rst(rst), .start(lctl.start), .win(lwin[g]),
      .top_dup(job_hold_q.top_dup), .left_dup(job_hold_q.left_dup),
      .rc(job_hold_q.rc), .cc(job_hold_q.cc), .krows(krows), .dvs(dvs),
      .done(ldone[g]), .result(lres[g])
    );
  end

  rgbc_merge u_merge (
    .clk(clk), .rst(rst), .lane_done(ldone), .lane_res(lres), .job(job_hold),
    .out_stall(out_stall), .out_valid(out_valid), .pix(opix), .job_out(job_out)
  );

  assign out_red    = opix[0];
  assign out_green  = opix[1];
  assign out_blue   = opix[2];
  assign out_alpha  = opix[3];
  assign out_row    = job_out.row[9:0];
  assign out_col    = job_out.col[9:0];
  assign run_last   = job_out.run_last;
  assign frame_last = job_out.frame_last;
endmodule

// ===== rtl/core/rgbc_checker.sv =====
// port level checks for the convolution unit
module rgbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       run_last,
  input logic       frame_last,
  input logic [7:0] out_red
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_red))
    else $error("stalled output changed");
  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> run_last)
    else $error("frame end without run end");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");
endmodule

bind rgba_convolution_3x3_unit rgbc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .run_last(run_last),
  .frame_last(frame_last), .out_red(out_red)
);

// ===== bench/tb_rgba_convolution_3x3_unit.sv =====
// self-checking bench for the rgba 3x3 convolution unit
`timescale 1ns / 100ps

module tb_rgba_convolution_3x3_unit;
  import rgbc_pkg::*;

  typedef struct {
    logic [7:0] red, green, blue, alpha;
  } pixel_t;

  typedef struct {
    logic [7:0] red, green, blue, alpha;
    logic [9:0] row, col;
    logic       run_last, frame_last;
  } conv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CfgKTop;
  logic [47:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic [9:0]  out_row, out_col;
  logic        run_last, frame_last;

  rgba_convolution_3x3_unit dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the block state
  logic [47:0] k_top, k_mid, k_bot;
  logic [15:0] div_reg;
  logic [10:0] wid_reg, hgt_reg;
  logic [31:0] upper_line [MaxWidth];
  logic [31:0] lower_line [MaxWidth];
  logic [31:0] win [9];
  int unsigned row_pos, col_pos;

  pixel_t       pixel_queue [$];
  conv_result_t expected_q [$];
  int errors = 0;
  int results_seen = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit in_taken = 1'b0;

  function automatic int unsigned eff_size(logic [10:0] v, int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic logic signed [15:0] kcoef(logic [47:0] kr, int k);
    return kr[16*k +: 16];
  endfunction

  // filtered pixel centred at window (rc,cc)
  function automatic conv_result_t filter_at(int unsigned r, int unsigned c,
                                             int rc, int cc);
    conv_result_t res;
    int rows [3];
    int cols [3];
    logic [47:0] kr [3];
    longint sum, dv;
    logic [7:0] chv [4];
    rows[0] = (r == 0) ? rc : rc - 1;
    rows[1] = rc;
    rows[2] = 2;
    cols[0] = (c == 0) ? cc : cc - 1;
    cols[1] = cc;
    cols[2] = 2;
    kr[0] = k_top; kr[1] = k_mid; kr[2] = k_bot;
    dv = (div_reg == 0) ? 1 : div_reg;
    for (int ch = 0; ch < 4; ch++) begin
      sum = 0;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          sum += longint'(win[rows[a]*3 + cols[b]][8*ch +: 8]) *
                 longint'(kcoef(kr[a], b));
      sum = sum / dv;
      if (sum > 255) sum = 255;
      if (sum < 0) sum = 0;
      chv[ch] = sum[7:0];
    end
    res.red = chv[0]; res.green = chv[1]; res.blue = chv[2]; res.alpha = chv[3];
    res.row = r[9:0];
    res.col = c[9:0];
    res.run_last = 1'b0;
    res.frame_last = 1'b0;
    return res;
  endfunction

  // advance the shadow state by one pixel and queue released outputs
  task automatic predict_pixel(pixel_t p);
    int unsigned w, h, r, c;
    logic [31:0] px, up, lo;
    bit lastc, lastr;
    conv_result_t outs [$];
    conv_result_t o;
    w = eff_size(wid_reg, MaxWidth);
    h = eff_size(hgt_reg, MaxHeight);
    r = row_pos;
    c = col_pos;
    if (c > w - 1) c = w - 1;
    if (r > h - 1) r = h - 1;
    px = {p.alpha, p.blue, p.green, p.red};
    up = upper_line[c];
    lo = lower_line[c];
    upper_line[c] = lo;
    lower_line[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up; win[5] = lo; win[8] = px;
    lastc = (c == w - 1);
    lastr = (r == h - 1);
    if (r >= 1) begin
      if (c >= 1) outs.push_back(filter_at(r - 1, c - 1, 1, 1));
      if (lastc) outs.push_back(filter_at(r - 1, c, 1, 2));
    end
    if (lastr) begin
      if (c >= 1) outs.push_back(filter_at(r, c - 1, 2, 1));
      if (lastc) begin
        o = filter_at(r, c, 2, 2);
        o.frame_last = 1'b1;
        outs.push_back(o);
      end
    end
    if (outs.size() > 0) outs[outs.size()-1].run_last = 1'b1;
    foreach (outs[i]) expected_q.push_back(outs[i]);
    if (lastc) begin
      col_pos = 0;
      row_pos = lastr ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  // driver: presents queued pixels, predicts on each transfer
  always @(posedge clk) begin
    pixel_t p;
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) begin
      p = pixel_queue.pop_front();
      predict_pixel(p);
    end
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_red <= pixel_queue[0].red;
        in_green <= pixel_queue[0].green;
        in_blue <= pixel_queue[0].blue;
        in_alpha <= pixel_queue[0].alpha;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    conv_result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result row %0d col %0d", $time, out_row, out_col);
      end else begin
        e = expected_q.pop_front();
        if ({out_red, out_green, out_blue, out_alpha, out_row, out_col, run_last,
             frame_last} !== {e.red, e.green, e.blue, e.alpha, e.row, e.col,
                              e.run_last, e.frame_last}) begin
          errors++;
          $display("%0t: mismatch exp rgba %h %h %h %h r%0d c%0d rl%b fl%b",
                   $time, e.red, e.green, e.blue, e.alpha, e.row, e.col,
                   e.run_last, e.frame_last);
          $display("%0t:          got rgba %h %h %h %h r%0d c%0d rl%b fl%b",
                   $time, out_red, out_green, out_blue, out_alpha, out_row,
                   out_col, run_last, frame_last);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgKTop: k_top = val;
      CfgKMid: k_mid = val;
      CfgKBot: k_bot = val;
      CfgDiv:  div_reg = val[15:0];
      CfgWid:  wid_reg = val[10:0];
      CfgHgt:  hgt_reg = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_kernel(logic [47:0] t, logic [47:0] m, logic [47:0] b,
                            logic [15:0] d);
    write_reg(CfgKTop, t);
    write_reg(CfgKMid, m);
    write_reg(CfgKBot, b);
    write_reg(CfgDiv, {32'd0, d});
  endtask

  // wait until every pixel is sent and every result has come
  task automatic drain();
    while (pixel_queue.size() > 0 || in_valid || expected_q.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.red = $urandom; p.green = $urandom; p.blue = $urandom; p.alpha = $urandom;
    return p;
  endfunction

  function automatic logic [47:0] rand_kernel_row();
    logic [47:0] v;
    for (int k = 0; k < 3; k++)
      v[16*k +: 16] = ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'($signed($urandom_range(8)) - 4);
    return v;
  endfunction

  task automatic queue_frame(int unsigned w, int unsigned h, int kind);
    pixel_t p;
    for (int i = 0; i < w * h; i++) begin
      case (kind)
        0: p = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        1: p = '{8'h00, 8'h00, 8'h00, 8'h00};
        default: p = rand_pixel();
      endcase
      pixel_queue.push_back(p);
    end
  endtask

  // stimulus
  initial begin
    int unsigned w, h;
    int frames;
    k_top = 48'd0; k_mid = 48'h10000; k_bot = 48'd0; div_reg = 16'd1;
    wid_reg = 11'd1024; hgt_reg = 11'd1024;
    row_pos = 0; col_pos = 0;
    foreach (win[i]) win[i] = '0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: identity kernel, 3x3 then 1x1 frames, saturation extremes, oversize widths and heights
    send_idle_pct = 11; recv_idle_pct = 77;
    write_reg(CfgWid, 48'd3);
    write_reg(CfgHgt, 48'd3);
    queue_frame(3, 3, 2);
    drain();
    set_kernel({16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000},
               {16'hFFFF, 16'h0001, 16'h0000}, 16'd0);
    write_reg(CfgWid, 48'd0);
    write_reg(CfgHgt, 48'd0);
    queue_frame(1, 1, 0);
    queue_frame(1, 1, 1);
    drain();
    set_kernel({3{16'h0001}}, {3{16'h0001}}, {3{16'h0001}}, 16'hFFFF);
    write_reg(CfgWid, 48'd2000);
    write_reg(CfgHgt, 48'd1);
    queue_frame(3, 1, 0);
    drain();
    set_kernel({3{16'hFFFF}}, {16'hFFFF, 16'h0008, 16'hFFFF}, {3{16'hFFFF}}, 16'd9);
    write_reg(CfgWid, 48'd1);
    write_reg(CfgHgt, 48'd2000);
    queue_frame(1, 3, 2);
    drain();
    // wide single row fills both line stores, then a wide two-row frame
    write_reg(CfgHgt, 48'd1);
    write_reg(CfgWid, 48'd48);
    queue_frame(48, 1, 2);
    drain();
    write_reg(CfgHgt, 48'd2);
    queue_frame(48, 2, 2);
    drain();

    // random frames over three idling regimes
    frames = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 11 : 0;
      for (int f = 0; f < 5; f++) begin
        w = $urandom_range(6, 1);
        h = $urandom_range(6, 1);
        set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                   ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(9)));
        write_reg(CfgWid, 48'(w));
        write_reg(CfgHgt, 48'(h));
        queue_frame(w, h, 2);
        drain();
        frames++;
      end
    end

    $display("covered %0d random frames plus directed edge, size and kernel cases",
             frames);
    $display("results checked: %0d, mismatches: %0d", results_seen, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/rgbc_pkg.sv
rtl/core/rgbc_ram.sv
rtl/core/rgbc_lane.sv
rtl/core/rgbc_merge.sv
rtl/core/rgba_convolution_3x3_unit.sv
rtl/core/rgbc_checker.sv
bench/tb_rgba_convolution_3x3_unit.sv
